>>> rtl/lsg_pkg.sv
// ----------------------------------------------------------------------------
// lsg_pkg: shared types and constants of the lidar sector guard
// Field widths, operation and result codes, register indexes and the
// structs that pass between the classifier, the velocity guard and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package lsg_pkg;

    localparam int RangeW   = 16;
    localparam int IndexW   = 12;
    localparam int ScanLenW = 13;
    localparam int VelW     = 16;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    // opcode of an input beat
    localparam logic OpSample   = 1'b0;
    localparam logic OpVelocity = 1'b1;

    // kind of a result beat
    localparam logic KindSummary  = 1'b0;
    localparam logic KindVelocity = 1'b1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgScanLength = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgNoiseFloor = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgFrontLimit = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgRearLimit  = 2'd3;

    localparam logic [RangeW-1:0]   RangeEmpty      = '1;
    localparam logic [ScanLenW-1:0] ScanLenReset    = 13'd1000;
    localparam logic [RangeW-1:0]   NoiseFloorReset = 16'd50;
    localparam logic [RangeW-1:0]   FrontLimitReset = 16'd1000;
    localparam logic [RangeW-1:0]   RearLimitReset  = 16'd3000;

    // sector decision for one range sample
    typedef struct packed {
        logic front_hit;
        logic front_danger;
        logic rear_hit;
        logic rear_danger;
    } sector_hit_t;

    // velocity guard decision
    typedef struct packed {
        logic            braking;
        logic [VelW-1:0] linear;
    } guard_t;

endpackage

`default_nettype wire

>>> rtl/lsg_sector_classify.sv
// ----------------------------------------------------------------------------
// lsg_sector_classify: sector decision for one range sample
// Saturates the scan length, places the sample index in the front or rear
// sector by exact integer ratio tests and checks noise floor and limits.
// ----------------------------------------------------------------------------
`default_nettype none

module lsg_sector_classify #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic [lsg_pkg::ScanLenW-1:0] scan_length,
    input  wire logic [lsg_pkg::RangeW-1:0]   noise_floor,
    input  wire logic [lsg_pkg::RangeW-1:0]   front_limit,
    input  wire logic [lsg_pkg::RangeW-1:0]   rear_limit,
    input  wire logic [lsg_pkg::RangeW-1:0]   range_mm,
    input  wire logic [lsg_pkg::IndexW-1:0]   sample_index,
    output lsg_pkg::sector_hit_t              hit
);

    localparam int ProdW = 18;

    logic [lsg_pkg::ScanLenW-1:0] used_len;
    logic [ProdW-1:0]             idx_x10;
    logic [ProdW-1:0]             idx_x20;
    logic [ProdW-1:0]             len_x4;
    logic [ProdW-1:0]             len_x6;
    logic [ProdW-1:0]             len_x3;
    logic [ProdW-1:0]             len_x17;
    logic                         in_front;
    logic                         in_rear;
    logic                         above_noise;

    // clamp scan length to one .. MAX_SAMPLES
    always_comb begin
        if (scan_length == '0) begin
            used_len = lsg_pkg::ScanLenW'(1);
        end else if (32'(scan_length) > 32'(MAX_SAMPLES)) begin
            used_len = lsg_pkg::ScanLenW'(MAX_SAMPLES);
        end else begin
            used_len = scan_length;
        end
    end

    // front: 0.4 n < i < 0.6 n; rear: i < 0.15 n or i > 0.85 n
    assign idx_x10 = ProdW'(sample_index) * ProdW'(10);
    assign idx_x20 = ProdW'(sample_index) * ProdW'(20);
    assign len_x4  = ProdW'(used_len) * ProdW'(4);
    assign len_x6  = ProdW'(used_len) * ProdW'(6);
    assign len_x3  = ProdW'(used_len) * ProdW'(3);
    assign len_x17 = ProdW'(used_len) * ProdW'(17);

    assign in_front    = (idx_x10 > len_x4) && (idx_x10 < len_x6);
    assign in_rear     = (idx_x20 < len_x3) || (idx_x20 > len_x17);
    assign above_noise = (range_mm >= noise_floor);

    assign hit.front_hit    = above_noise && in_front;
    assign hit.front_danger = above_noise && in_front && (range_mm < front_limit);
    assign hit.rear_hit     = above_noise && !in_front && in_rear;
    assign hit.rear_danger  = above_noise && !in_front && in_rear && (range_mm < rear_limit);

endmodule

`default_nettype wire

>>> rtl/lsg_velocity_guard.sv
// ----------------------------------------------------------------------------
// lsg_velocity_guard: linear velocity braking
// Zeroes a forward command when the front is blocked and a reverse command
// when the rear is blocked; a zero command never brakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lsg_velocity_guard (
    input  wire logic [lsg_pkg::VelW-1:0] linear_cmd,
    input  wire logic                     front_flag,
    input  wire logic                     rear_flag,
    output lsg_pkg::guard_t               guard
);

    logic moving_back;
    logic moving_fwd;

    assign moving_back = linear_cmd[lsg_pkg::VelW-1];
    assign moving_fwd  = (linear_cmd != '0) && !moving_back;

    // brake into a blocked direction, pass otherwise
    assign guard.braking = (moving_fwd && front_flag) || (moving_back && rear_flag);
    assign guard.linear  = guard.braking ? '0 : linear_cmd;

endmodule

`default_nettype wire

>>> rtl/lidar_sector_guard_velocity_filter.sv
// ----------------------------------------------------------------------------
// lidar_sector_guard_velocity_filter: lidar sector guard with velocity filter
// A result is registered in the cycle after its beat is accepted. One beat
// per cycle while m_ready drains the output register, which is refilled in
// the same cycle its beat is taken. Synchronous active-low reset restores
// the register defaults, clears the blocked flags and restarts the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_sector_guard_velocity_filter #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [lsg_pkg::CfgIdxW-1:0]       cfg_index,
    input  wire logic [lsg_pkg::CfgDataW-1:0]      cfg_data,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_opcode,
    input  wire logic [lsg_pkg::RangeW-1:0]        s_range_mm,
    input  wire logic [lsg_pkg::IndexW-1:0]        s_sample_index,
    input  wire logic                              s_last_sample,
    input  wire logic signed [lsg_pkg::VelW-1:0]   s_linear_cmd,
    input  wire logic signed [lsg_pkg::VelW-1:0]   s_angular_cmd,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_result_kind,
    output logic                                   m_front_is_blocked,
    output logic                                   m_rear_is_blocked,
    output logic [lsg_pkg::RangeW-1:0]             m_front_min_mm,
    output logic [lsg_pkg::RangeW-1:0]             m_rear_min_mm,
    output logic signed [lsg_pkg::VelW-1:0]        m_linear_out,
    output logic signed [lsg_pkg::VelW-1:0]        m_angular_out,
    output logic                                   m_braking
);

    logic [lsg_pkg::ScanLenW-1:0] scan_length_reg;
    logic [lsg_pkg::RangeW-1:0]   noise_floor_reg;
    logic [lsg_pkg::RangeW-1:0]   front_limit_reg;
    logic [lsg_pkg::RangeW-1:0]   rear_limit_reg;

    logic                         front_flag_reg;
    logic                         rear_flag_reg;
    logic                         front_danger_reg;
    logic                         front_danger_next;
    logic                         rear_danger_reg;
    logic                         rear_danger_next;
    logic [lsg_pkg::RangeW-1:0]   front_min_reg;
    logic [lsg_pkg::RangeW-1:0]   front_min_next;
    logic [lsg_pkg::RangeW-1:0]   rear_min_reg;
    logic [lsg_pkg::RangeW-1:0]   rear_min_next;

    logic                         out_valid_reg;
    logic                         kind_reg;
    logic                         front_blk_reg;
    logic                         rear_blk_reg;
    logic [lsg_pkg::RangeW-1:0]   out_front_min_reg;
    logic [lsg_pkg::RangeW-1:0]   out_rear_min_reg;
    logic [lsg_pkg::VelW-1:0]     linear_reg;
    logic [lsg_pkg::VelW-1:0]     angular_reg;
    logic                         braking_reg;

    lsg_pkg::sector_hit_t         hit;
    lsg_pkg::guard_t              guard;
    logic                         in_beat;
    logic                         is_sample;
    logic                         emit;

    // sector decision and braking decision
    lsg_sector_classify #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_classify (
        .scan_length  (scan_length_reg),
        .noise_floor  (noise_floor_reg),
        .front_limit  (front_limit_reg),
        .rear_limit   (rear_limit_reg),
        .range_mm     (s_range_mm),
        .sample_index (s_sample_index),
        .hit          (hit)
    );

    lsg_velocity_guard u_guard (
        .linear_cmd (s_linear_cmd),
        .front_flag (front_flag_reg),
        .rear_flag  (rear_flag_reg),
        .guard      (guard)
    );

    // take a beat whenever the output register is free or being drained
    assign s_ready   = !out_valid_reg || m_ready;
    assign in_beat   = s_valid && s_ready;
    assign is_sample = (s_opcode == lsg_pkg::OpSample);
    assign emit      = !is_sample || s_last_sample;

    // fold the current sample into the scan accumulators
    always_comb begin
        front_danger_next = front_danger_reg || hit.front_danger;
        rear_danger_next  = rear_danger_reg || hit.rear_danger;
        front_min_next    = front_min_reg;
        rear_min_next     = rear_min_reg;
        if (hit.front_hit && (s_range_mm < front_min_reg)) begin
            front_min_next = s_range_mm;
        end
        if (hit.rear_hit && (s_range_mm < rear_min_reg)) begin
            rear_min_next = s_range_mm;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_length_reg <= lsg_pkg::ScanLenReset;
            noise_floor_reg <= lsg_pkg::NoiseFloorReset;
            front_limit_reg <= lsg_pkg::FrontLimitReset;
            rear_limit_reg  <= lsg_pkg::RearLimitReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lsg_pkg::CfgScanLength: begin
                    scan_length_reg <= cfg_data[lsg_pkg::ScanLenW-1:0];
                end
                lsg_pkg::CfgNoiseFloor: begin
                    noise_floor_reg <= cfg_data;
                end
                lsg_pkg::CfgFrontLimit: begin
                    front_limit_reg <= cfg_data;
                end
                lsg_pkg::CfgRearLimit: begin
                    rear_limit_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // scan accumulators and latched flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_flag_reg   <= 1'b0;
            rear_flag_reg    <= 1'b0;
            front_danger_reg <= 1'b0;
            rear_danger_reg  <= 1'b0;
            front_min_reg    <= lsg_pkg::RangeEmpty;
            rear_min_reg     <= lsg_pkg::RangeEmpty;
        end else if (in_beat && is_sample) begin
            if (s_last_sample) begin
                front_flag_reg   <= front_danger_next;
                rear_flag_reg    <= rear_danger_next;
                front_danger_reg <= 1'b0;
                rear_danger_reg  <= 1'b0;
                front_min_reg    <= lsg_pkg::RangeEmpty;
                rear_min_reg     <= lsg_pkg::RangeEmpty;
            end else begin
                front_danger_reg <= front_danger_next;
                rear_danger_reg  <= rear_danger_next;
                front_min_reg    <= front_min_next;
                rear_min_reg     <= rear_min_next;
            end
        end
    end

    // output valid: set on a result, drop when taken without refill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_beat && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (in_beat && emit) begin
            if (is_sample) begin
                kind_reg          <= lsg_pkg::KindSummary;
                front_blk_reg     <= front_danger_next;
                rear_blk_reg      <= rear_danger_next;
                out_front_min_reg <= front_min_next;
                out_rear_min_reg  <= rear_min_next;
                linear_reg        <= '0;
                angular_reg       <= '0;
                braking_reg       <= 1'b0;
            end else begin
                kind_reg          <= lsg_pkg::KindVelocity;
                front_blk_reg     <= front_flag_reg;
                rear_blk_reg      <= rear_flag_reg;
                out_front_min_reg <= '0;
                out_rear_min_reg  <= '0;
                linear_reg        <= guard.linear;
                angular_reg       <= s_angular_cmd;
                braking_reg       <= guard.braking;
            end
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_result_kind      = kind_reg;
    assign m_front_is_blocked = front_blk_reg;
    assign m_rear_is_blocked  = rear_blk_reg;
    assign m_front_min_mm     = out_front_min_reg;
    assign m_rear_min_mm      = out_rear_min_reg;
    assign m_linear_out       = linear_reg;
    assign m_angular_out      = angular_reg;
    assign m_braking          = braking_reg;

    // a velocity beat always yields a velocity result next cycle
    a_velocity_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_opcode == lsg_pkg::OpVelocity)
            |=> (out_valid_reg && kind_reg == lsg_pkg::KindVelocity))
        else $error("velocity beat did not produce a velocity result");

    // a last sample always yields a summary next cycle
    a_summary_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_opcode == lsg_pkg::OpSample && s_last_sample)
            |=> (out_valid_reg && kind_reg == lsg_pkg::KindSummary))
        else $error("last sample did not produce a summary");

    // braking only ever appears on a velocity result
    a_brake_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && braking_reg) |-> (kind_reg == lsg_pkg::KindVelocity))
        else $error("braking set on a scan summary");

    // a braked command carries a blocked flag in its direction
    a_brake_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && braking_reg) |-> (front_blk_reg || rear_blk_reg))
        else $error("braking without a blocked sector");

endmodule

`default_nettype wire
